@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers used by the answer reader back end.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bgar_pkg.sv @@
// ----------------------------------------------------------------------------
// bgar_pkg
// Shared types, sizes, codes and helpers of the bubble grid answer reader.
// ----------------------------------------------------------------------------
package bgar_pkg;

    localparam int QUESTIONS  = 10;
    localparam int CHOICES    = 5;
    localparam int BOXES      = QUESTIONS * CHOICES;

    localparam int COORD_W    = 10;
    localparam int SIDE_W     = 6;
    localparam int PITCH_W    = 8;
    localparam int POS_W      = 13;   // start + span of the farthest box
    localparam int BAL_W      = 13;
    localparam int QIDX_W     = 4;
    localparam int CODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(CHOICES + 1);

    localparam logic signed [BAL_W-1:0] BAL_MAX = BAL_W'(4095);
    localparam logic signed [BAL_W-1:0] BAL_MIN = BAL_W'(-4096);

    localparam logic [COORD_W-1:0] RST_ORIGIN_X = COORD_W'(48);
    localparam logic [COORD_W-1:0] RST_ORIGIN_Y = COORD_W'(61);
    localparam logic [SIDE_W-1:0]  RST_BOX_W    = SIDE_W'(24);
    localparam logic [SIDE_W-1:0]  RST_BOX_H    = SIDE_W'(12);
    localparam logic [PITCH_W-1:0] RST_PITCH_X  = PITCH_W'(31);
    localparam logic [PITCH_W-1:0] RST_PITCH_Y  = PITCH_W'(22);

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_W    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_H    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_Y  = 3'd5;

    localparam logic [CODE_W-1:0] ANS_BLANK    = 3'd0;
    localparam logic [CODE_W-1:0] ANS_ANNULLED = CODE_W'(CHOICES + 1);

    typedef struct packed {
        logic [QUESTIONS-1:0] row_hit;
        logic [CHOICES-1:0]   col_hit;
        logic                 inked;
        logic                 frame_end;
    } t_entry;

    function automatic logic [CODE_W-1:0] f_answer_code(input logic [CHOICES-1:0] marks);
        logic [CNT_W-1:0]  cnt;
        logic [CODE_W-1:0] single;
        cnt    = '0;
        single = '0;
        for (int c = 0; c < CHOICES; c++) begin
            if (marks[c]) begin
                cnt    = cnt + CNT_W'(1);
                single = CODE_W'(c + 1);
            end
        end
        if (cnt == '0) begin
            f_answer_code = ANS_BLANK;
        end else if (cnt == CNT_W'(1)) begin
            f_answer_code = single;
        end else begin
            f_answer_code = ANS_ANNULLED;
        end
    endfunction

endpackage

@@ rtl/bgar_front.sv @@
// ----------------------------------------------------------------------------
// bgar_front
// Grid registers and window compares: turns a pixel into row and column hits.
// ----------------------------------------------------------------------------
module bgar_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bgar_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bgar_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [bgar_pkg::COORD_W-1:0]      i_pixel_x,
    input  logic [bgar_pkg::COORD_W-1:0]      i_pixel_y,
    input  logic                              i_pixel_inked,
    input  logic                              i_frame_end,
    output bgar_pkg::t_entry                  o_entry
);

    logic [bgar_pkg::COORD_W-1:0] r_origin_x;
    logic [bgar_pkg::COORD_W-1:0] r_origin_y;
    logic [bgar_pkg::SIDE_W-1:0]  r_box_w;
    logic [bgar_pkg::SIDE_W-1:0]  r_box_h;
    logic [bgar_pkg::PITCH_W-1:0] r_pitch_x;
    logic [bgar_pkg::PITCH_W-1:0] r_pitch_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= bgar_pkg::RST_ORIGIN_X;
            r_origin_y <= bgar_pkg::RST_ORIGIN_Y;
            r_box_w    <= bgar_pkg::RST_BOX_W;
            r_box_h    <= bgar_pkg::RST_BOX_H;
            r_pitch_x  <= bgar_pkg::RST_PITCH_X;
            r_pitch_y  <= bgar_pkg::RST_PITCH_Y;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bgar_pkg::CFG_ORIGIN_X: r_origin_x <= i_cfg_data;
                bgar_pkg::CFG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                bgar_pkg::CFG_BOX_W:    r_box_w    <= i_cfg_data[bgar_pkg::SIDE_W-1:0];
                bgar_pkg::CFG_BOX_H:    r_box_h    <= i_cfg_data[bgar_pkg::SIDE_W-1:0];
                bgar_pkg::CFG_PITCH_X:  r_pitch_x  <= i_cfg_data[bgar_pkg::PITCH_W-1:0];
                bgar_pkg::CFG_PITCH_Y:  r_pitch_y  <= i_cfg_data[bgar_pkg::PITCH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic [bgar_pkg::POS_W-1:0] px;
    logic [bgar_pkg::POS_W-1:0] py;
    logic [bgar_pkg::POS_W-1:0] row_start [bgar_pkg::QUESTIONS];
    logic [bgar_pkg::POS_W-1:0] col_start [bgar_pkg::CHOICES];

    assign px = bgar_pkg::POS_W'(i_pixel_x);
    assign py = bgar_pkg::POS_W'(i_pixel_y);

    // pitch times a constant index: shifts and adds only
    always_comb begin
        for (int q = 0; q < bgar_pkg::QUESTIONS; q++) begin
            row_start[q] = bgar_pkg::POS_W'(r_origin_y)
                         + bgar_pkg::POS_W'(q) * bgar_pkg::POS_W'(r_pitch_y);
            o_entry.row_hit[q] = (py >= row_start[q])
                               && (py <= row_start[q] + bgar_pkg::POS_W'(r_box_h));
        end
        for (int c = 0; c < bgar_pkg::CHOICES; c++) begin
            col_start[c] = bgar_pkg::POS_W'(r_origin_x)
                         + bgar_pkg::POS_W'(c) * bgar_pkg::POS_W'(r_pitch_x);
            o_entry.col_hit[c] = (px >= col_start[c])
                               && (px <= col_start[c] + bgar_pkg::POS_W'(r_box_w));
        end
        o_entry.inked     = i_pixel_inked;
        o_entry.frame_end = i_frame_end;
    end

endmodule

@@ rtl/bgar_fifo.sv @@
// ----------------------------------------------------------------------------
// bgar_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module bgar_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bgar_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output bgar_pkg::t_entry o_head
);

    bgar_pkg::t_entry                r_mem [bgar_pkg::FIFO_DEPTH];
    logic [bgar_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [bgar_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [bgar_pkg::FIFO_PTR_W:0]   r_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_full  = (r_count == (bgar_pkg::FIFO_PTR_W + 1)'(bgar_pkg::FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + bgar_pkg::FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + bgar_pkg::FIFO_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (bgar_pkg::FIFO_PTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (bgar_pkg::FIFO_PTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/bgar_back.sv @@
// ----------------------------------------------------------------------------
// bgar_back
// Box balance cells and per-question result emission on frame end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bgar_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_head_valid,
    input  bgar_pkg::t_entry                   i_head,
    output logic                               o_pop,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [bgar_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    output logic                               o_m_axis_tlast
);

    typedef enum logic {S_ACCUM, S_EMIT} t_state;

    t_state                            r_state;
    logic signed [bgar_pkg::BAL_W-1:0] r_bal [bgar_pkg::BOXES];
    logic signed [bgar_pkg::BAL_W-1:0] n_bal [bgar_pkg::BOXES];
    logic [bgar_pkg::BOXES-1:0]        r_marks;
    logic [bgar_pkg::BOXES-1:0]        n_snap;
    logic [bgar_pkg::QIDX_W-1:0]       r_pos;
    logic                              r_out_valid;
    logic [bgar_pkg::QIDX_W-1:0]       r_out_qidx;
    logic [bgar_pkg::CODE_W-1:0]       r_out_code;
    logic [bgar_pkg::CHOICES-1:0]      r_out_marks;
    logic                              r_out_last;
    logic                              load_out;
    logic                              pos_last;

    assign o_pop    = i_head_valid && (r_state == S_ACCUM);
    assign load_out = (r_state == S_EMIT) && (!r_out_valid || i_m_axis_tready);
    assign pos_last = (r_pos == bgar_pkg::QIDX_W'(bgar_pkg::QUESTIONS - 1));

    always_comb begin
        for (int q = 0; q < bgar_pkg::QUESTIONS; q++) begin
            for (int c = 0; c < bgar_pkg::CHOICES; c++) begin
                n_bal[q*bgar_pkg::CHOICES+c] = r_bal[q*bgar_pkg::CHOICES+c];
                if (i_head.row_hit[q] && i_head.col_hit[c]) begin
                    if (i_head.inked) begin
                        if (r_bal[q*bgar_pkg::CHOICES+c] != bgar_pkg::BAL_MAX) begin
                            n_bal[q*bgar_pkg::CHOICES+c] =
                                r_bal[q*bgar_pkg::CHOICES+c] + bgar_pkg::BAL_W'(1);
                        end
                    end else begin
                        if (r_bal[q*bgar_pkg::CHOICES+c] != bgar_pkg::BAL_MIN) begin
                            n_bal[q*bgar_pkg::CHOICES+c] =
                                r_bal[q*bgar_pkg::CHOICES+c] - bgar_pkg::BAL_W'(1);
                        end
                    end
                end
            end
        end
        // tie counts as marked
        for (int b = 0; b < bgar_pkg::BOXES; b++) begin
            n_snap[b] = !r_bal[b][bgar_pkg::BAL_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < bgar_pkg::BOXES; b++) begin
                r_bal[b] <= '0;
            end
        end else if (o_pop) begin
            for (int b = 0; b < bgar_pkg::BOXES; b++) begin
                r_bal[b] <= i_head.frame_end ? '0 : n_bal[b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACCUM;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_ACCUM: begin
                    if (o_pop && i_head.frame_end) begin
                        r_marks <= n_snap;
                        r_pos   <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (load_out) begin
                        r_out_qidx  <= r_pos;
                        r_out_marks <= r_marks[bgar_pkg::CHOICES-1:0];
                        r_out_code  <= bgar_pkg::f_answer_code(r_marks[bgar_pkg::CHOICES-1:0]);
                        r_out_last  <= pos_last;
                        r_marks     <= r_marks >> bgar_pkg::CHOICES;
                        if (pos_last) begin
                            r_state <= S_ACCUM;
                        end else begin
                            r_pos <= r_pos + bgar_pkg::QIDX_W'(1);
                        end
                    end
                end
                default: r_state <= S_ACCUM;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = bgar_pkg::OUT_DATA_W'({r_out_marks, r_out_code, r_out_qidx});

    `ASSERT_CLK(a_no_pop_emit, i_clk, i_rst_n, (r_state == S_EMIT) |-> !o_pop, "pop during emission")
    `ASSERT_CLK(a_frame_to_emit, i_clk, i_rst_n, (o_pop && i_head.frame_end) |=> (r_state == S_EMIT), "frame end did not start emission")
    `ASSERT_CLK(a_last_index, i_clk, i_rst_n, (r_out_valid && r_out_last) |-> (r_out_qidx == bgar_pkg::QIDX_W'(bgar_pkg::QUESTIONS - 1)), "last flag on wrong question")

endmodule

@@ rtl/bubble_grid_answer_reader.sv @@
// ----------------------------------------------------------------------------
// bubble_grid_answer_reader
// Counts inked versus clear pixels per answer box and reports each question.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid/tready          tdata: pixel_x, pixel_y, pixel_inked; tlast: frame_end
//   m_axis    out  tvalid/tready          tdata: question_index, answer_code, marked_choices;
//                                         tlast: last_of_run
//   cfg       in   we (no wait)           index, data
//
// One pixel per cycle outside emission; compares are combinational, balance updates registered.
// A frame end gives ten results, one per cycle while the sink takes them; pixel updates
// wait meanwhile and the 4-entry queue absorbs the first pixels of the next sheet.
// Synchronous reset clears all balances at once; no clearing pass.
// A stalled sink holds the output register; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module bubble_grid_answer_reader (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [bgar_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,  // pixel_x, pixel_y, pixel_inked
    input  logic                               i_s_axis_tlast,  // frame_end
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [bgar_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,  // question_index, answer_code,
                                                                // marked_choices
    output logic                               o_m_axis_tlast,  // last_of_run
    input  logic                               i_cfg_we,
    input  logic [bgar_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bgar_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    bgar_pkg::t_entry front_entry;
    bgar_pkg::t_entry head;
    logic             fifo_full;
    logic             head_valid;
    logic             pop;

    assign o_s_axis_tready = !fifo_full;

    bgar_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pixel_x     (i_s_axis_tdata[9:0]),
        .i_pixel_y     (i_s_axis_tdata[19:10]),
        .i_pixel_inked (i_s_axis_tdata[20]),
        .i_frame_end   (i_s_axis_tlast),
        .o_entry       (front_entry)
    );

    bgar_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_axis_tvalid),
        .i_entry (front_entry),
        .o_full  (fifo_full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head)
    );

    bgar_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (head_valid),
        .i_head          (head),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

@@ sim/bgar_checker.sv @@
// ----------------------------------------------------------------------------
// bgar_checker
// Watches the pixel, answer and register traffic of the answer reader. Keeps
// its own grid setup and per-box tallies, grades each sheet on frame end and
// compares every answer item, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bgar_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    input  logic [bgar_pkg::IN_DATA_W-1:0]     i_s_tdata,   // pixel_x, pixel_y, pixel_inked
    input  logic                               i_s_tlast,   // frame_end
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [bgar_pkg::OUT_DATA_W-1:0]    i_m_tdata,   // question_index, answer_code,
                                                            // marked_choices
    input  logic                               i_m_tlast,   // last_of_run
    input  logic                               i_cfg_we,
    input  logic [bgar_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bgar_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_answers_seen
);

    localparam int CODE_LO = bgar_pkg::QIDX_W;
    localparam int MARK_LO = bgar_pkg::QIDX_W + bgar_pkg::CODE_W;

    typedef struct packed {
        logic [bgar_pkg::QIDX_W-1:0]  qidx;
        logic [bgar_pkg::CODE_W-1:0]  code;
        logic [bgar_pkg::CHOICES-1:0] marks;
        logic                         last;
    } t_answer;

    t_answer                           answer_q[$];
    logic signed [bgar_pkg::BAL_W-1:0] tally [bgar_pkg::BOXES];
    logic [bgar_pkg::COORD_W-1:0]      org_x, org_y;
    logic [bgar_pkg::SIDE_W-1:0]       side_w, side_h;
    logic [bgar_pkg::PITCH_W-1:0]      step_x, step_y;
    int                                fails = 0;
    int                                answers_seen = 0;

    task automatic note_mismatch(input string msg);
        fails++;
        if (fails <= 10) begin
            $display("bgar_checker: %s", msg);
        end
    endtask

    task automatic tally_pixel(input logic [bgar_pkg::COORD_W-1:0] px,
                               input logic [bgar_pkg::COORD_W-1:0] py,
                               input logic ink);
        int row0;
        int col0;
        int idx;
        for (int q = 0; q < bgar_pkg::QUESTIONS; q++) begin
            row0 = int'(org_y) + q * int'(step_y);
            if (int'(py) >= row0 && int'(py) <= row0 + int'(side_h)) begin
                for (int c = 0; c < bgar_pkg::CHOICES; c++) begin
                    col0 = int'(org_x) + c * int'(step_x);
                    idx  = q * bgar_pkg::CHOICES + c;
                    if (int'(px) >= col0 && int'(px) <= col0 + int'(side_w)) begin
                        if (ink) begin
                            if (tally[idx] != bgar_pkg::BAL_MAX) begin
                                tally[idx] = tally[idx] + bgar_pkg::BAL_W'(1);
                            end
                        end else begin
                            if (tally[idx] != bgar_pkg::BAL_MIN) begin
                                tally[idx] = tally[idx] - bgar_pkg::BAL_W'(1);
                            end
                        end
                    end
                end
            end
        end
    endtask

    task automatic grade_sheet();
        t_answer a;
        int      hits;
        for (int q = 0; q < bgar_pkg::QUESTIONS; q++) begin
            a.marks = '0;
            a.code  = bgar_pkg::ANS_BLANK;
            hits    = 0;
            for (int c = 0; c < bgar_pkg::CHOICES; c++) begin
                // zero or more counts as marked
                if (!tally[q * bgar_pkg::CHOICES + c][bgar_pkg::BAL_W-1]) begin
                    a.marks[c] = 1'b1;
                    a.code     = bgar_pkg::CODE_W'(c + 1);
                    hits++;
                end
            end
            if (hits == 0) begin
                a.code = bgar_pkg::ANS_BLANK;
            end else if (hits > 1) begin
                a.code = bgar_pkg::ANS_ANNULLED;
            end
            a.qidx = bgar_pkg::QIDX_W'(q);
            a.last = (q == bgar_pkg::QUESTIONS - 1);
            answer_q.push_back(a);
        end
        for (int i = 0; i < bgar_pkg::BOXES; i++) tally[i] = '0;
    endtask

    always @(posedge i_clk) begin : watch
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            org_x  = bgar_pkg::RST_ORIGIN_X;
            org_y  = bgar_pkg::RST_ORIGIN_Y;
            side_w = bgar_pkg::RST_BOX_W;
            side_h = bgar_pkg::RST_BOX_H;
            step_x = bgar_pkg::RST_PITCH_X;
            step_y = bgar_pkg::RST_PITCH_Y;
            for (int i = 0; i < bgar_pkg::BOXES; i++) tally[i] = '0;
            answer_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bgar_pkg::CFG_ORIGIN_X: org_x  = i_cfg_data[bgar_pkg::COORD_W-1:0];
                    bgar_pkg::CFG_ORIGIN_Y: org_y  = i_cfg_data[bgar_pkg::COORD_W-1:0];
                    bgar_pkg::CFG_BOX_W:    side_w = i_cfg_data[bgar_pkg::SIDE_W-1:0];
                    bgar_pkg::CFG_BOX_H:    side_h = i_cfg_data[bgar_pkg::SIDE_W-1:0];
                    bgar_pkg::CFG_PITCH_X:  step_x = i_cfg_data[bgar_pkg::PITCH_W-1:0];
                    bgar_pkg::CFG_PITCH_Y:  step_y = i_cfg_data[bgar_pkg::PITCH_W-1:0];
                    default: ;
                endcase
            end
            // answers first: an item out now never belongs to a sheet closed now
            if (i_m_tvalid && i_m_tready) begin
                got.qidx  = i_m_tdata[bgar_pkg::QIDX_W-1:0];
                got.code  = i_m_tdata[CODE_LO+bgar_pkg::CODE_W-1:CODE_LO];
                got.marks = i_m_tdata[MARK_LO+bgar_pkg::CHOICES-1:MARK_LO];
                got.last  = i_m_tlast;
                answers_seen++;
                if (answer_q.size() == 0) begin
                    note_mismatch($sformatf("answer item q%0d arrived with none expected",
                                            got.qidx));
                end else begin
                    want = answer_q.pop_front();
                    if (got.qidx != want.qidx)
                        note_mismatch($sformatf("question_index exp %0d got %0d",
                                                want.qidx, got.qidx));
                    if (got.code != want.code)
                        note_mismatch($sformatf("answer_code q%0d exp %0d got %0d",
                                                want.qidx, want.code, got.code));
                    if (got.marks != want.marks)
                        note_mismatch($sformatf("marked_choices q%0d exp %05b got %05b",
                                                want.qidx, want.marks, got.marks));
                    if (got.last != want.last)
                        note_mismatch($sformatf("last_of_run q%0d exp %0b got %0b",
                                                want.qidx, want.last, got.last));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tlast) begin
                    grade_sheet();
                end else begin
                    tally_pixel(i_s_tdata[bgar_pkg::COORD_W-1:0],
                                i_s_tdata[2*bgar_pkg::COORD_W-1:bgar_pkg::COORD_W],
                                i_s_tdata[2*bgar_pkg::COORD_W]);
                end
            end
        end
        o_pending      <= answer_q.size();
        o_fail_count   <= fails;
        o_answers_seen <= answers_seen;
    end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the bubble grid answer reader. Drives directed
// sheets at the reset setup, then random sheets under extreme and random
// grid setups, with bursty pixel traffic and a stalling answer sink.
// Checking is done by bgar_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam logic [bgar_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [bgar_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} t_rx_mode;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            s_tvalid   = 1'b0;
    logic                            s_tready;
    logic [bgar_pkg::IN_DATA_W-1:0]  s_tdata    = '0;
    logic                            s_tlast    = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready   = 1'b0;
    logic [bgar_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tlast;
    logic                            cfg_we     = 1'b0;
    logic [bgar_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [bgar_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

    int       fail_count;
    int       pending;
    int       answers_seen;
    int       items_sent = 0;
    int       sheets_sent = 0;
    int       setups = 0;
    int       burst_left = 0;
    int       idle_cycles = 0;
    int       cur_ox, cur_oy, cur_bw, cur_bh, cur_px, cur_py;
    logic     hold_go = 1'b0;
    logic     hold_done = 1'b0;
    int       hold_left = 0;
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       beat = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bubble_grid_answer_reader dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    bgar_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tlast      (s_tlast),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tlast      (m_tlast),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_answers_seen (answers_seen)
    );

    // answer sink: changing stall patterns, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = RX_HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 80);
            end else begin
                rx_left = rx_left - 1;
            end
            beat = beat + 1;
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= (beat % 5 != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic offer(input logic [bgar_pkg::COORD_W-1:0] x,
                         input logic [bgar_pkg::COORD_W-1:0] y,
                         input logic ink, input logic fe);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, ink, y, x};
        s_tlast  <= fe;
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
        if (fe) sheets_sent++;
    endtask

    task automatic sheet_end();
        offer(10'($urandom), 10'($urandom), 1'($urandom), 1'b1);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [bgar_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bgar_pkg::CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge i_clk);
    endtask

    // unused upper data bits are randomized; the block must keep only the field
    task automatic apply_setup(input logic [bgar_pkg::COORD_W-1:0] ox,
                               input logic [bgar_pkg::COORD_W-1:0] oy,
                               input logic [bgar_pkg::SIDE_W-1:0] bw,
                               input logic [bgar_pkg::SIDE_W-1:0] bh,
                               input logic [bgar_pkg::PITCH_W-1:0] px,
                               input logic [bgar_pkg::PITCH_W-1:0] py);
        cfg_write(bgar_pkg::CFG_ORIGIN_X, ox);
        cfg_write(bgar_pkg::CFG_ORIGIN_Y, oy);
        cfg_write(bgar_pkg::CFG_BOX_W, {4'($urandom), bw});
        cfg_write(bgar_pkg::CFG_BOX_H, {4'($urandom), bh});
        cfg_write(bgar_pkg::CFG_PITCH_X, {2'($urandom), px});
        cfg_write(bgar_pkg::CFG_PITCH_Y, {2'($urandom), py});
        cfg_write($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 10'($urandom));
        cfg_we <= 1'b0;
        cur_ox = ox;
        cur_oy = oy;
        cur_bw = bw;
        cur_bh = bh;
        cur_px = px;
        cur_py = py;
        setups++;
    endtask

    function automatic logic [bgar_pkg::COORD_W-1:0] aim_x(input int c);
        return 10'(cur_ox + c * cur_px + $urandom_range(0, cur_bw));
    endfunction

    function automatic logic [bgar_pkg::COORD_W-1:0] aim_y(input int q);
        return 10'(cur_oy + q * cur_py + $urandom_range(0, cur_bh));
    endfunction

    // clear every box of a question but one; keep == CHOICES leaves it blank
    task automatic fill_question(input int q, input int keep);
        for (int c = 0; c < bgar_pkg::CHOICES; c++) begin
            if (c != keep) offer(aim_x(c), aim_y(q), 1'b0, 1'b0);
        end
    endtask

    task automatic run_phase(input bit with_hold);
        int  n;
        int  bias;
        int  filled;
        logic ink;
        for (int f = 0; f < 2; f++) begin
            filled = (with_hold && f == 1) ? 0 : $urandom_range(0, 2);
            n      = (with_hold && f == 1) ? 12 : $urandom_range(0, 4);
            bias   = $urandom_range(0, 3);
            for (int k = 0; k < filled; k++) begin
                fill_question($urandom_range(0, bgar_pkg::QUESTIONS - 1),
                              $urandom_range(0, bgar_pkg::CHOICES));
            end
            for (int i = 0; i < n; i++) begin
                case (bias)
                    0:       ink = ($urandom_range(0, 3) == 0);
                    2:       ink = ($urandom_range(0, 3) != 0);
                    default: ink = 1'($urandom_range(0, 1));
                endcase
                if ($urandom_range(0, 5) == 0) begin
                    offer(10'($urandom), 10'($urandom), ink, 1'b0);
                end else begin
                    offer(aim_x($urandom_range(0, bgar_pkg::CHOICES - 1)),
                          aim_y($urandom_range(0, bgar_pkg::QUESTIONS - 1)), ink, 1'b0);
                end
            end
            // sink holds off while the next sheet's pixels pile up behind
            if (with_hold && f == 0) hold_go <= 1'b1;
            sheet_end();
        end
        wait_idle();
    endtask

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setup: columns 48/79/110/141/172 wide 25, rows from 61 by 22, tall 13
        sheet_end();                        // untouched sheet: ties, all annulled
        offer(10'd0, 10'd0, 1'b1, 1'b0);
        offer(10'd1023, 10'd1023, 1'b0, 1'b0);
        offer(10'd1023, 10'd0, 1'b1, 1'b0);
        offer(10'd0, 10'd1023, 1'b0, 1'b0);
        offer(10'd72, 10'd73, 1'b1, 1'b0);  // q0: only A left marked
        offer(10'd79, 10'd61, 1'b0, 1'b0);
        offer(10'd134, 10'd73, 1'b0, 1'b0);
        offer(10'd141, 10'd73, 1'b0, 1'b0);
        offer(10'd196, 10'd61, 1'b0, 1'b0);
        offer(10'd48, 10'd95, 1'b0, 1'b0);  // q1: blank
        offer(10'd103, 10'd83, 1'b0, 1'b0);
        offer(10'd110, 10'd90, 1'b0, 1'b0);
        offer(10'd165, 10'd95, 1'b0, 1'b0);
        offer(10'd172, 10'd83, 1'b0, 1'b0);
        offer(10'd73, 10'd105, 1'b0, 1'b0); // just between boxes
        offer(10'd48, 10'd104, 1'b0, 1'b0); // just between rows
        offer(10'd60, 10'd127, 1'b0, 1'b0); // q3: C
        offer(10'd90, 10'd139, 1'b0, 1'b0);
        offer(10'd150, 10'd130, 1'b0, 1'b0);
        offer(10'd180, 10'd135, 1'b0, 1'b0);
        offer(10'd48, 10'd271, 1'b0, 1'b0); // q9: E
        offer(10'd79, 10'd259, 1'b0, 1'b0);
        offer(10'd110, 10'd265, 1'b0, 1'b0);
        offer(10'd141, 10'd271, 1'b0, 1'b0);
        sheet_end();
        wait_idle();

        apply_setup(10'd0, 10'd0, 6'd63, 6'd63, 8'd1, 8'd1);
        run_phase(1'b1);
        apply_setup(10'd1023, 10'd1023, 6'd0, 6'd0, 8'd255, 8'd255);
        run_phase(1'b0);
        apply_setup(10'($urandom_range(0, 900)), 10'($urandom_range(0, 900)),
                    6'($urandom), 6'($urandom), 8'd0, 8'd0);
        run_phase(1'b0);
        apply_setup(bgar_pkg::RST_ORIGIN_X, bgar_pkg::RST_ORIGIN_Y,
                    bgar_pkg::RST_BOX_W, bgar_pkg::RST_BOX_H,
                    bgar_pkg::RST_PITCH_X, bgar_pkg::RST_PITCH_Y);
        run_phase(1'b0);
        for (int k = 0; k < 2; k++) begin
            apply_setup((k == 1) ? 10'($urandom) : 10'($urandom_range(0, 200)),
                        (k == 1) ? 10'($urandom) : 10'($urandom_range(0, 200)),
                        6'($urandom), 6'($urandom), 8'($urandom), 8'($urandom));
            run_phase(1'b0);
        end

        $display("tb: %0d items sent in %0d sheets over %0d grid setups", items_sent,
                 sheets_sent, setups);
        $display("tb: %0d answer items checked, %0d mismatches", answers_seen, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

@@ bubble_grid_answer_reader.f @@
+incdir+rtl
rtl/bgar_pkg.sv
rtl/bgar_front.sv
rtl/bgar_fifo.sv
rtl/bgar_back.sv
rtl/bubble_grid_answer_reader.sv
sim/bgar_checker.sv
sim/tb.sv
